// ===== rtl/core/sacl_pkg.sv =====
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types, constants and helpers of the set-associative cache controller.
// ----------------------------------------------------------------------------
package sacl_pkg;

  localparam int ADDR_W          = 64;
  localparam int STAMP_W         = 32;
  localparam int OUT_W           = 72;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 4;
  localparam int MAX_OFFSET_BITS = 12;
  localparam int MAX_INDEX_BITS  = 6;
  localparam int RAW_SET_W       = 6;

  localparam int DEF_MAX_SETS = 64;
  localparam int DEF_MAX_WAYS = 8;
  localparam int DEF_TAG_BITS = 32;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WR_THRU     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WR_ALLOC    = 3'd4;

  localparam logic [1:0] KIND_HIT      = 2'd0;
  localparam logic [1:0] KIND_COLD     = 2'd1;
  localparam logic [1:0] KIND_CONFLICT = 2'd2;

  typedef struct packed {
    logic [3:0] offset_bits;
    logic [2:0] index_bits;
    logic [3:0] ways_in_use;
    logic       wr_thru;
    logic       wr_alloc;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    offset_bits: 4'd6, index_bits: 3'd6, ways_in_use: 4'd8,
    wr_thru: 1'b0, wr_alloc: 1'b0
  };

  function automatic logic [3:0] eff_ob(input logic [3:0] v);
    return (v > 4'(MAX_OFFSET_BITS)) ? 4'(MAX_OFFSET_BITS) : v;
  endfunction

  function automatic logic [2:0] eff_ib(input logic [2:0] v);
    return (v > 3'(MAX_INDEX_BITS)) ? 3'(MAX_INDEX_BITS) : v;
  endfunction

endpackage

// ===== rtl/core/set_assoc_cache_lru_controller.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_controller
// Tag and LRU controller of a set-associative cache with write-back option.
//
//   Port group   Direction  Beat contents
//   in_*         slave      tdata: addr; tuser: is_read
//   out_*        master     tdata: hit, miss_kind, way, lower_request,
//                           victim_writeback, victim_addr
//   cfg_*        slave      register index and value
//
// In the back end each access is a set read in S_IDLE, then the compare,
// victim choice and set write in S_EVAL, which waits while the output is held.
// Reset is synchronous; it clears all lines through per-set valid bits.
// A write to a defined configuration register (0 to 4) invalidates all lines.
// A two-entry queue lets the front accept while the result waits.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_controller import sacl_pkg::*; #(
  parameter int MAX_SETS = DEF_MAX_SETS,
  parameter int MAX_WAYS = DEF_MAX_WAYS,
  parameter int TAG_BITS = DEF_TAG_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [ADDR_W-1:0]     in_tdata,   // [63:0] addr
  input  logic                  in_tuser,   // [0] is_read
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [0] hit, [2:1] miss_kind, [5:3] way, [6] lower_request,
  // [7] victim_writeback, [71:8] victim_addr
  output logic [OUT_W-1:0]      out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;

  cfg_t                cfg_r, cfg_nxt;
  logic                cfg_clear;
  logic                q_valid, q_pop, q_rd;
  logic [SET_W-1:0]    q_set;
  logic [TAG_BITS-1:0] q_tag;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt   = cfg_r;
    cfg_clear = 1'b0;
    if (cfg_valid) begin
      cfg_clear = 1'b1;
      unique case (cfg_index)
        REG_OFFSET_BITS: cfg_nxt.offset_bits = cfg_data;
        REG_INDEX_BITS:  cfg_nxt.index_bits  = cfg_data[2:0];
        REG_WAYS_IN_USE: cfg_nxt.ways_in_use = cfg_data;
        REG_WR_THRU:     cfg_nxt.wr_thru     = cfg_data[0];
        REG_WR_ALLOC:    cfg_nxt.wr_alloc    = cfg_data[0];
        default:         cfg_clear           = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  sacl_front #(.MAX_SETS(MAX_SETS), .TAG_BITS(TAG_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_addr  (in_tdata),
    .in_rd    (in_tuser),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_rd     (q_rd),
    .q_set    (q_set),
    .q_tag    (q_tag)
  );

  sacl_back #(.MAX_SETS(MAX_SETS), .MAX_WAYS(MAX_WAYS), .TAG_BITS(TAG_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cfg_clear (cfg_clear),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_rd      (q_rd),
    .q_set     (q_set),
    .q_tag     (q_tag),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

`ifndef SYNTH
  a_wb_conflict: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[7] |-> (out_tdata[2:1] == KIND_CONFLICT) && out_tdata[6])
    else $error("writeback without conflict miss");

  a_hit_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] == (out_tdata[2:1] == KIND_HIT)))
    else $error("hit flag disagrees with miss kind");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");
`endif

endmodule

// ===== rtl/core/sacl_ram.sv =====
// ----------------------------------------------------------------------------
// sacl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/sacl_front.sv =====
// ----------------------------------------------------------------------------
// sacl_front
// Accepts accesses, splits the address into set and tag, and queues them.
// ----------------------------------------------------------------------------
module sacl_front import sacl_pkg::*; #(
  parameter int MAX_SETS = DEF_MAX_SETS,
  parameter int TAG_BITS = DEF_TAG_BITS,
  localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cfg_t                cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [ADDR_W-1:0]   in_addr,
  input  logic                in_rd,
  output logic                q_valid,
  input  logic                q_pop,
  output logic                q_rd,
  output logic [SET_W-1:0]    q_set,
  output logic [TAG_BITS-1:0] q_tag
);

  function automatic logic [SET_W-1:0] wrap_set(input logic [RAW_SET_W-1:0] s);
    logic [12:0] rem;
    rem = '0;
    for (int i = RAW_SET_W - 1; i >= 0; i--) begin
      rem = {rem[11:0], s[i]};
      if (rem >= 13'(MAX_SETS)) begin
        rem = rem - 13'(MAX_SETS);
      end
    end
    return SET_W'(rem);
  endfunction

  logic [3:0]           ob;
  logic [2:0]           ib;
  logic [ADDR_W-1:0]    shifted;
  logic [RAW_SET_W-1:0] raw_set;
  logic [SET_W-1:0]     set_c;
  logic [TAG_BITS-1:0]  tag_c;
  logic                 push;

  logic                rd_r  [2];
  logic [SET_W-1:0]    set_r [2];
  logic [TAG_BITS-1:0] tag_r [2];
  logic                wptr_r, wptr_nxt;
  logic                rptr_r, rptr_nxt;
  logic [1:0]          cnt_r, cnt_nxt;

  always_comb begin
    ob      = eff_ob(cfg.offset_bits);
    ib      = eff_ib(cfg.index_bits);
    shifted = in_addr >> ob;
    raw_set = shifted[RAW_SET_W-1:0] & RAW_SET_W'((7'd1 << ib) - 7'd1);
    set_c   = wrap_set(raw_set);
    tag_c   = TAG_BITS'(in_addr >> (5'(ob) + 5'(ib)));
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_rd     = rd_r[rptr_r];
  assign q_set    = set_r[rptr_r];
  assign q_tag    = tag_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r ^ push;
    rptr_nxt = rptr_r ^ (q_pop && q_valid);
    cnt_nxt  = cnt_r + 2'(push) - 2'(q_pop && q_valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      rd_r[wptr_r]  <= in_rd;
      set_r[wptr_r] <= set_c;
      tag_r[wptr_r] <= tag_c;
    end
  end

endmodule

// ===== rtl/core/sacl_back.sv =====
// ----------------------------------------------------------------------------
// sacl_back
// Reads a set, resolves hit, fill or LRU victim, and writes the set back on a hit or an allocating miss.
// ----------------------------------------------------------------------------
module sacl_back import sacl_pkg::*; #(
  parameter int MAX_SETS = DEF_MAX_SETS,
  parameter int MAX_WAYS = DEF_MAX_WAYS,
  parameter int TAG_BITS = DEF_TAG_BITS,
  localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cfg_t                cfg,
  input  logic                cfg_clear,
  input  logic                q_valid,
  output logic                q_pop,
  input  logic                q_rd,
  input  logic [SET_W-1:0]    q_set,
  input  logic [TAG_BITS-1:0] q_tag,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [OUT_W-1:0]    out_data
);

  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int LINE_W = 2 + TAG_BITS + STAMP_W;
  localparam int ROW_W  = MAX_WAYS * LINE_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EVAL = 2'b10
  } state_t;

  state_t              state_r, state_nxt;
  logic [SET_W-1:0]    set_r;
  logic [TAG_BITS-1:0] tag_r;
  logic                rd_r;
  logic                rvq_r;
  logic [MAX_SETS-1:0] rv_r, rv_nxt;
  logic [STAMP_W-1:0]  clock_r, clock_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]    out_data_r;

  logic [ROW_W-1:0]    rdata, row, nrow;
  logic                fire, we;
  logic [4:0]          nways;
  logic [STAMP_W-1:0]  stamp_new;

  logic                v  [MAX_WAYS];
  logic                d  [MAX_WAYS];
  logic [TAG_BITS-1:0] tg [MAX_WAYS];
  logic [STAMP_W-1:0]  st [MAX_WAYS];

  logic                found, have_free;
  logic [WAY_W-1:0]    hidx, fidx, lidx, target;
  logic [STAMP_W-1:0]  best;
  logic                hit, lower, wb, alloc;
  logic [1:0]          kind;
  logic [ADDR_W-1:0]   vaddr;
  logic [LINE_W-1:0]   line;
  logic [3:0]          ob;
  logic [4:0]          tb;

  sacl_ram #(.WIDTH(ROW_W), .DEPTH(MAX_SETS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (set_r),
    .wdata (nrow),
    .re    (state_r == S_IDLE),
    .raddr (q_set),
    .rdata (rdata)
  );

  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign fire      = (state_r == S_EVAL) && (!out_valid_r || out_ready);
  assign stamp_new = clock_r + STAMP_W'(1);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    if (cfg.ways_in_use == 4'd0) begin
      nways = 5'd1;
    end else if (5'(cfg.ways_in_use) > 5'(MAX_WAYS)) begin
      nways = 5'(MAX_WAYS);
    end else begin
      nways = 5'(cfg.ways_in_use);
    end
  end

  always_comb begin
    row = rvq_r ? rdata : '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      v[w]  = row[w*LINE_W];
      d[w]  = row[w*LINE_W+1];
      tg[w] = row[w*LINE_W+2 +: TAG_BITS];
      st[w] = row[w*LINE_W+2+TAG_BITS +: STAMP_W];
    end
    found     = 1'b0;
    have_free = 1'b0;
    hidx      = '0;
    fidx      = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (5'(w) < nways) begin
        if (!found && v[w] && (tg[w] == tag_r)) begin
          found = 1'b1;
          hidx  = WAY_W'(w);
        end
        if (!have_free && !v[w]) begin
          have_free = 1'b1;
          fidx      = WAY_W'(w);
        end
      end
    end
    best = st[0];
    lidx = '0;
    for (int w = 1; w < MAX_WAYS; w++) begin
      if ((5'(w) < nways) && (st[w] < best)) begin
        best = st[w];
        lidx = WAY_W'(w);
      end
    end

    ob     = eff_ob(cfg.offset_bits);
    tb     = 5'(ob) + 5'(eff_ib(cfg.index_bits));
    hit    = found;
    kind   = found ? KIND_HIT : (have_free ? KIND_COLD : KIND_CONFLICT);
    alloc  = !found && (rd_r || cfg.wr_alloc);
    lower  = found ? (!rd_r && cfg.wr_thru) : 1'b1;
    wb     = 1'b0;
    vaddr  = '0;
    target = '0;
    if (found) begin
      target = hidx;
    end else if (alloc) begin
      target = have_free ? fidx : lidx;
      if (!have_free && !cfg.wr_thru && d[lidx]) begin
        wb    = 1'b1;
        vaddr = (ADDR_W'(tg[lidx]) << tb) | (ADDR_W'(set_r) << ob);
      end
    end

    line = row[int'(target)*LINE_W +: LINE_W];
    if (found) begin
      line[2+TAG_BITS +: STAMP_W] = stamp_new;
      if (!rd_r && !cfg.wr_thru) begin
        line[1] = 1'b1;
      end
    end else begin
      line = {stamp_new, tag_r, 1'b0, 1'b1};
    end
    nrow = row;
    nrow[int'(target)*LINE_W +: LINE_W] = line;
    we   = fire && (found || alloc);
  end

  always_comb begin
    state_nxt     = state_r;
    clock_nxt     = clock_r;
    rv_nxt        = rv_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (fire) begin
          state_nxt     = S_IDLE;
          clock_nxt     = stamp_new;
          out_valid_nxt = 1'b1;
          if (we) begin
            rv_nxt[set_r] = 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cfg_clear) begin
      rv_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      clock_r     <= '0;
      rv_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clock_r     <= clock_nxt;
      rv_r        <= rv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      set_r <= q_set;
      tag_r <= q_tag;
      rd_r  <= q_rd;
      rvq_r <= rv_r[q_set];
    end
    if (fire) begin
      out_data_r <= {vaddr, wb, lower, 3'(target), kind, hit};
    end
  end

endmodule
